>>> rtl/spvi_pkg.sv
package spvi_pkg;

   // Square root produces one root bit per stage, the divider one quotient bit per stage.
   localparam int SQ_STEPS = 48;
   localparam int DV_STEPS = 33;
   localparam int MUL_LAT = 4;

   // Positions along the back end's pipeline, counted from the entry stage.
   localparam int IDX_ROOT = SQ_STEPS;
   localparam int IDX_NUM = IDX_ROOT + 1;
   localparam int IDX_Q = IDX_NUM + DV_STEPS;
   localparam int IDX_IND = IDX_Q + MUL_LAT;
   localparam int IDX_PROD = IDX_IND + MUL_LAT;

   // Start to result strobe: difference stage, multiplier, d2 stage, queue write,
   // pop into the back end, back end pipeline, output register.
   localparam int RSP_LAT = 1 + MUL_LAT + 1 + 1 + 1 + IDX_PROD + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [64:0] FATIGUE_STEP = 65'd4294967;
   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_ORIGIN_Z,
      CSR_DIR_X,
      CSR_DIR_Y,
      CSR_DIR_Z,
      CSR_RADIUS,
      CSR_INDENT_GAIN
   } csr_index_type;

   typedef struct packed {
      logic [2:0][63:0] origin;
      logic [2:0][63:0] dir;
      logic [62:0]      radius;
      logic [63:0]      gain;
   } cfg_type;

   typedef struct packed {
      logic [2:0][63:0] v;
      logic [63:0]      fatigue;
      logic             last;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic [63:0] finc;
      logic [62:0] d2;
      logic        hit;
   } entry_type;

   typedef struct packed {
      item_type    item;
      logic [63:0] finc;
      logic        hit;
   } side_type;

endpackage

>>> rtl/spvi_mul.sv
// Signed Q32.32 multiply of two 65-bit operands, saturated to 64 bits, four stages.
module spvi_mul (
   input  logic        clock,
   input  logic [64:0] a,
   input  logic [64:0] b,
   output logic [63:0] q
);

   logic [64:0]       a_abs, b_abs;
   logic [63:0]       am_ff, bm_ff;
   logic              n0_ff, n1_ff, n2_ff;
   logic [3:0][63:0]  pp_ff;
   logic [127:0]      prod_ff;
   logic [63:0]       q_ff;
   logic [63:0]       cap, r, mag;
   logic              over;

   always_comb begin
      a_abs = a[64] ? -a : a;
      b_abs = b[64] ? -b : b;
   end

   always_comb begin
      cap = n2_ff ? spvi_pkg::SMIN : spvi_pkg::SMAX;
      over = |prod_ff[127:96];
      r = prod_ff[95:32];
      mag = (over || (r > cap)) ? cap : r;
   end

   always_ff @(posedge clock) begin
      am_ff <= a_abs[63:0];
      bm_ff <= b_abs[63:0];
      n0_ff <= a[64] ^ b[64];
      pp_ff[0] <= am_ff[31:0] * bm_ff[31:0];
      pp_ff[1] <= am_ff[31:0] * bm_ff[63:32];
      pp_ff[2] <= am_ff[63:32] * bm_ff[31:0];
      pp_ff[3] <= am_ff[63:32] * bm_ff[63:32];
      n1_ff <= n0_ff;
      prod_ff <= {64'b0, pp_ff[0]} + {32'b0, pp_ff[1], 32'b0} + {32'b0, pp_ff[2], 32'b0}
               + {pp_ff[3], 64'b0};
      n2_ff <= n1_ff;
      q_ff <= n2_ff ? -mag : mag;
   end

   assign q = q_ff;

endmodule

>>> rtl/spvi_front.sv
// Front end: squared distance to the origin and the inside test.
module spvi_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  spvi_pkg::item_type   req_item,
   input  logic [63:0]          req_pressure,
   input  spvi_pkg::cfg_type    cfg,
   output logic                 push_valid,
   output spvi_pkg::entry_type  push_entry
);

   logic [2:0][64:0]   diff_ff;
   logic [63:0]        pres_ff;
   spvi_pkg::item_type it_ff [0:spvi_pkg::MUL_LAT];
   logic               vld_ff [0:spvi_pkg::MUL_LAT];
   logic [2:0][63:0]   sq;
   logic [63:0]        r2, finc;
   logic [64:0]        sum;
   logic [62:0]        d2;
   logic               push_valid_ff;
   spvi_pkg::entry_type push_entry_ff;

   for (genvar a = 0; a < 3; a++) begin : g_sq
      spvi_mul u_sq (.clock(clock), .a(diff_ff[a]), .b(diff_ff[a]), .q(sq[a]));
   end

   spvi_mul u_r2 (
      .clock(clock),
      .a({2'b00, cfg.radius}),
      .b({2'b00, cfg.radius}),
      .q(r2)
   );

   spvi_mul u_finc (
      .clock(clock),
      .a({pres_ff[63], pres_ff}),
      .b(spvi_pkg::FATIGUE_STEP),
      .q(finc)
   );

   always_comb begin
      sum = {1'b0, sq[0]} + {1'b0, sq[1]} + {1'b0, sq[2]};
      d2 = (sum > {1'b0, spvi_pkg::SMAX}) ? spvi_pkg::SMAX[62:0] : sum[62:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= spvi_pkg::MUL_LAT; k++) vld_ff[k] <= 1'b0;
         push_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k <= spvi_pkg::MUL_LAT; k++) vld_ff[k] <= vld_ff[k-1];
         push_valid_ff <= vld_ff[spvi_pkg::MUL_LAT];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         diff_ff[a] <= {req_item.v[a][63], req_item.v[a]}
                     - {cfg.origin[a][63], cfg.origin[a]};
      end
      pres_ff <= req_pressure;
      it_ff[0] <= req_item;
      for (int k = 1; k <= spvi_pkg::MUL_LAT; k++) it_ff[k] <= it_ff[k-1];
      push_entry_ff.item <= it_ff[spvi_pkg::MUL_LAT];
      push_entry_ff.finc <= finc;
      push_entry_ff.d2 <= d2;
      push_entry_ff.hit <= ({1'b0, d2} < r2);
   end

   assign push_valid = push_valid_ff;
   assign push_entry = push_entry_ff;

   // r2 never exceeds the largest positive value, so an inside word cannot carry a
   // saturated distance.
   a_inside_unsat: assert property (@(posedge clock) disable iff (reset)
      push_valid_ff && push_entry_ff.hit |-> push_entry_ff.d2 != spvi_pkg::SMAX[62:0])
      else $error("inside word with saturated d2");

endmodule

>>> rtl/spvi_queue.sv
// Short queue between front end and back end.
module spvi_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  spvi_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   output spvi_pkg::entry_type  pop_entry,
   output logic                 full
);

   spvi_pkg::entry_type               mem_ff [0:spvi_pkg::QUEUE_DEPTH-1];
   logic [spvi_pkg::QPTR_W-1:0]       wr_ff, rd_ff;
   logic [spvi_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                              push, pop;

   always_comb begin
      full = (cnt_ff == spvi_pkg::QCNT_W'(spvi_pkg::QUEUE_DEPTH));
      pop = (cnt_ff != '0);
      push = push_valid && !full;
      cnt_in = cnt_ff + spvi_pkg::QCNT_W'(push) - spvi_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

   assign pop_valid = pop;
   assign pop_entry = mem_ff[rd_ff];

   // The back end drains a word every cycle, so the queue never holds more than one.
   a_shallow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= spvi_pkg::QCNT_W'(1))
      else $error("queue holds more than one word");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("word pushed into full queue");

endmodule

>>> rtl/spvi_back.sv
// Back end: square root, falloff divide, indentation products, final adds.
module spvi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  spvi_pkg::entry_type  pop_entry,
   input  spvi_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   output spvi_pkg::item_type   rsp_item,
   output logic                 rsp_inside
);

   localparam int SQ = spvi_pkg::SQ_STEPS;
   localparam int DV = spvi_pkg::DV_STEPS;

   function automatic logic [63:0] sadd(input logic [63:0] x, input logic [63:0] y);
      logic [64:0] s;
      s = {x[63], x} + {y[63], y};
      if (s[64] != s[63]) return s[64] ? spvi_pkg::SMIN : spvi_pkg::SMAX;
      return s[63:0];
   endfunction

   logic                sbv_ff [0:spvi_pkg::IDX_PROD];
   spvi_pkg::side_type  sbd_ff [0:spvi_pkg::IDX_PROD];

   logic [SQ+1:0]       sq_rem_ff  [0:SQ];
   logic [SQ-1:0]       sq_root_ff [0:SQ];
   logic [2*SQ-1:0]     sq_n_ff    [0:SQ];

   logic [63:0]         num_ff, den;
   logic [63:0]         dv_rem_ff [0:DV-1];
   logic [DV-1:0]       dv_q_ff   [0:DV-1];

   logic [63:0]         ind;
   logic [2:0][63:0]    prod;

   logic                rsp_valid_ff;
   spvi_pkg::item_type  rsp_item_ff;
   logic                rsp_inside_ff;

   assign den = {1'b0, cfg.radius};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= spvi_pkg::IDX_PROD; k++) sbv_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sbv_ff[0] <= pop_valid;
         for (int k = 1; k <= spvi_pkg::IDX_PROD; k++) sbv_ff[k] <= sbv_ff[k-1];
         rsp_valid_ff <= sbv_ff[spvi_pkg::IDX_PROD];
      end
   end

   always_ff @(posedge clock) begin
      sbd_ff[0].item <= pop_entry.item;
      sbd_ff[0].finc <= pop_entry.finc;
      sbd_ff[0].hit <= pop_entry.hit;
      for (int k = 1; k <= spvi_pkg::IDX_PROD; k++) sbd_ff[k] <= sbd_ff[k-1];
      sq_rem_ff[0] <= '0;
      sq_root_ff[0] <= '0;
      sq_n_ff[0] <= {1'b0, pop_entry.d2, 32'b0};
      num_ff <= den - {16'b0, sq_root_ff[SQ]};
   end

   // Digit-by-digit square root, two radicand bits in per stage.
   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      logic [SQ+3:0] r, t, d;
      logic          ge;
      always_comb begin
         r = {sq_rem_ff[i], sq_n_ff[i][2*SQ-1 -: 2]};
         t = {2'b00, sq_root_ff[i], 2'b01};
         d = r - t;
         ge = (r >= t);
      end
      always_ff @(posedge clock) begin
         sq_rem_ff[i+1] <= ge ? d[SQ+1:0] : r[SQ+1:0];
         sq_root_ff[i+1] <= {sq_root_ff[i][SQ-2:0], ge};
         sq_n_ff[i+1] <= {sq_n_ff[i][2*SQ-3:0], 2'b00};
      end
   end

   // Restoring divider for the falloff weight. Since for an inside word the numerator
   // is at most the radius, the first step takes it unshifted and yields the integer bit.
   for (genvar k = 0; k < DV; k++) begin : g_div
      logic [63:0]   r_src, d;
      logic [DV-1:0] q_src;
      logic          ge;
      if (k == 0) begin : g_head
         always_comb begin
            r_src = num_ff;
            q_src = '0;
         end
      end else begin : g_tail
         always_comb begin
            r_src = {dv_rem_ff[k-1][62:0], 1'b0};
            q_src = dv_q_ff[k-1];
         end
      end
      always_comb begin
         ge = (r_src >= den);
         d = r_src - den;
      end
      always_ff @(posedge clock) begin
         dv_rem_ff[k] <= ge ? d : r_src;
         dv_q_ff[k] <= {q_src[DV-2:0], ge};
      end
   end

   spvi_mul u_ind (
      .clock(clock),
      .a({cfg.gain[63], cfg.gain}),
      .b({(65 - DV)'(0), dv_q_ff[DV-1]}),
      .q(ind)
   );

   for (genvar a = 0; a < 3; a++) begin : g_dir
      spvi_mul u_dir (
         .clock(clock),
         .a({cfg.dir[a][63], cfg.dir[a]}),
         .b({ind[63], ind}),
         .q(prod[a])
      );
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         rsp_item_ff.v[a] <= sbd_ff[spvi_pkg::IDX_PROD].hit
                           ? sadd(sbd_ff[spvi_pkg::IDX_PROD].item.v[a], prod[a])
                           : sbd_ff[spvi_pkg::IDX_PROD].item.v[a];
      end
      rsp_item_ff.fatigue <= sbd_ff[spvi_pkg::IDX_PROD].hit
                           ? sadd(sbd_ff[spvi_pkg::IDX_PROD].item.fatigue,
                                  sbd_ff[spvi_pkg::IDX_PROD].finc)
                           : sbd_ff[spvi_pkg::IDX_PROD].item.fatigue;
      rsp_item_ff.last <= sbd_ff[spvi_pkg::IDX_PROD].item.last;
      rsp_inside_ff <= sbd_ff[spvi_pkg::IDX_PROD].hit;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;
   assign rsp_inside = rsp_inside_ff;

endmodule

>>> rtl/spherical_poke_vertex_indent.sv
// rsp_valid pulses for each word taken with start, after the front end, the queue and the back end.
// Throughput: one vertex per clock while busy is low; every unit in the path is fully pipelined.
// The latency is set chiefly by the 48-stage square root and the 33-stage divider.
// busy stays low in normal flow; results cannot be held off by the receiver.
// Reset (synchronous, active high) empties the pipeline and the queue and
// returns the registers to origin 0, direction 0, radius 1.0, gain 0.
module spherical_poke_vertex_indent (
   input  logic        clock,
   input  logic        reset,

   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_vertex_x,
   input  logic [63:0] req_vertex_y,
   input  logic [63:0] req_vertex_z,
   input  logic [63:0] req_fatigue_in,
   input  logic [63:0] req_pressure_in,
   input  logic        req_last_vertex,

   output logic        rsp_valid,
   output logic [63:0] rsp_new_x,
   output logic [63:0] rsp_new_y,
   output logic [63:0] rsp_new_z,
   output logic [63:0] rsp_fatigue_out,
   output logic        rsp_inside_res,
   output logic        rsp_last_out,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   spvi_pkg::cfg_type   cfg_ff;
   spvi_pkg::item_type  req_item, rsp_item;
   logic                accept;
   logic                push_valid, pop_valid, full;
   spvi_pkg::entry_type push_entry, pop_entry;

   // The register port never stalls; writes are taken every cycle they are offered.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.dir <= '0;
         cfg_ff.radius <= 63'h1_0000_0000;
         cfg_ff.gain <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (spvi_pkg::csr_index_type'(csr_index))
            spvi_pkg::CSR_ORIGIN_X:    cfg_ff.origin[0] <= csr_data;
            spvi_pkg::CSR_ORIGIN_Y:    cfg_ff.origin[1] <= csr_data;
            spvi_pkg::CSR_ORIGIN_Z:    cfg_ff.origin[2] <= csr_data;
            spvi_pkg::CSR_DIR_X:       cfg_ff.dir[0] <= csr_data;
            spvi_pkg::CSR_DIR_Y:       cfg_ff.dir[1] <= csr_data;
            spvi_pkg::CSR_DIR_Z:       cfg_ff.dir[2] <= csr_data;
            // The radius is a 63-bit magnitude; the top data bit is dropped.
            spvi_pkg::CSR_RADIUS:      cfg_ff.radius <= csr_data[62:0];
            spvi_pkg::CSR_INDENT_GAIN: cfg_ff.gain <= csr_data;
            default:                   cfg_ff <= cfg_ff;
         endcase
      end
   end

   // A vertex word is taken whenever start is high and the queue has room. The
   // queue is drained every cycle, so in practice busy never rises.
   assign busy = full;
   assign accept = start && !busy;

   always_comb begin
      req_item.v[0] = req_vertex_x;
      req_item.v[1] = req_vertex_y;
      req_item.v[2] = req_vertex_z;
      req_item.fatigue = req_fatigue_in;
      req_item.last = req_last_vertex;
   end

   // The front end forms the squared distance and decides whether the vertex lies
   // inside the poke sphere; the fatigue increment is formed there as well.
   spvi_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_item(req_item),
      .req_pressure(req_pressure_in),
      .cfg(cfg_ff),
      .push_valid(push_valid),
      .push_entry(push_entry)
   );

   spvi_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .pop_valid(pop_valid),
      .pop_entry(pop_entry),
      .full(full)
   );

   // The back end runs every word through the same stages, inside or not, and
   // picks the moved or the original vertex at its output register.
   spvi_back u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_entry(pop_entry),
      .cfg(cfg_ff),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .rsp_inside(rsp_inside_res)
   );

   assign rsp_new_x = rsp_item.v[0];
   assign rsp_new_y = rsp_item.v[1];
   assign rsp_new_z = rsp_item.v[2];
   assign rsp_fatigue_out = rsp_item.fatigue;
   assign rsp_last_out = rsp_item.last;

   // Every accepted word comes out after the fixed pipeline latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(spvi_pkg::RSP_LAT) rsp_valid)
      else $error("result strobe missing at expected latency");

endmodule

>>> tb/tb_top.sv
module tb_top;

   // The run budget covers every vertex with its longest gap, all register
   // phases, and the drain time of the pipeline, several times over.
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 10;
   localparam int WORDS_PER_PHASE = 175;
   localparam logic [63:0] SMAX = spvi_pkg::SMAX;
   localparam logic [63:0] SMIN = spvi_pkg::SMIN;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_vertex_x = '0;
   logic [63:0] req_vertex_y = '0;
   logic [63:0] req_vertex_z = '0;
   logic [63:0] req_fatigue_in = '0;
   logic [63:0] req_pressure_in = '0;
   logic        req_last_vertex = 1'b0;
   logic        rsp_valid;
   logic [63:0] rsp_new_x;
   logic [63:0] rsp_new_y;
   logic [63:0] rsp_new_z;
   logic [63:0] rsp_fatigue_out;
   logic        rsp_inside_res;
   logic        rsp_last_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   spherical_poke_vertex_indent uut (.*);

   always #5 clock = ~clock;

   // One vertex word as it enters, and one poked vertex as it should leave.
   typedef struct {
      logic [63:0] x, y, z, fatigue, pressure;
      logic        last;
   } vertex_word_type;

   typedef struct {
      logic [63:0] x, y, z, fatigue;
      logic        hit, last;
   } poked_vertex_type;

   // Shadow copy of the register file, kept in step with each accepted write.
   logic [63:0] poke_origin [3];
   logic [63:0] poke_dir [3];
   logic [62:0] poke_radius;
   logic [63:0] poke_gain;

   poked_vertex_type pending_vertices [$];
   int mismatches = 0;
   int cycles = 0;
   int burst_left = 0;

   localparam logic [63:0] ONE_Q = 64'h1_0000_0000;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // (a*b) >> 32 for unsigned magnitudes, clamped at cap.
   function automatic logic [63:0] qmul_cap(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:96] != 0) return cap;
      return (p[95:32] > cap) ? cap : p[95:32];
   endfunction

   // Signed Q32.32 product, truncated toward zero, then saturated.
   function automatic logic [63:0] qmul_signed(logic [63:0] a, logic [63:0] b);
      logic neg;
      logic [63:0] ma, mb, m;
      neg = a[63] ^ b[63];
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      m = qmul_cap(ma, mb, neg ? SMIN : SMAX);
      return neg ? -m : m;
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
   endfunction

   function automatic logic [63:0] square_of_gap(logic [63:0] v, logic [63:0] o);
      logic [63:0] m;
      m = ($signed(v) >= $signed(o)) ? v - o : o - v;
      return qmul_cap(m, m, SMAX);
   endfunction

   // floor(sqrt(d2 * 2^32)), built one root bit at a time from the top.
   function automatic logic [63:0] root_of_d2(logic [63:0] d2);
      logic [127:0] target, sq;
      logic [63:0] r, c;
      target = {64'd0, d2} << 32;
      r = '0;
      for (int b = 47; b >= 0; b--) begin
         c = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (sq <= target) r = c;
      end
      return r;
   endfunction

   // Computes the poked vertex from the shadow registers.
   function automatic poked_vertex_type poke_vertex(vertex_word_type w);
      poked_vertex_type o;
      logic [63:0] d2, r2, root_dist, weight, indent, s;
      logic [127:0] quot;
      o.x = w.x;
      o.y = w.y;
      o.z = w.z;
      o.fatigue = w.fatigue;
      o.hit = 1'b0;
      o.last = w.last;
      s = square_of_gap(w.x, poke_origin[0]) + square_of_gap(w.y, poke_origin[1]);
      d2 = (s > SMAX) ? SMAX : s;
      s = d2 + square_of_gap(w.z, poke_origin[2]);
      d2 = (s > SMAX) ? SMAX : s;
      r2 = qmul_cap({1'b0, poke_radius}, {1'b0, poke_radius}, SMAX);
      if (d2 < r2) begin
         root_dist = root_of_d2(d2);
         quot = {32'd0, {1'b0, poke_radius} - root_dist, 32'd0} / {65'd0, poke_radius};
         weight = quot[63:0];
         indent = qmul_signed(poke_gain, weight);
         o.x = add_sat(w.x, qmul_signed(poke_dir[0], indent));
         o.y = add_sat(w.y, qmul_signed(poke_dir[1], indent));
         o.z = add_sat(w.z, qmul_signed(poke_dir[2], indent));
         o.fatigue = add_sat(w.fatigue,
                             qmul_signed(w.pressure, spvi_pkg::FATIGUE_STEP[63:0]));
         o.hit = 1'b1;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result checker: every strobe must match the oldest pending vertex.
   always @(posedge clock) begin
      poked_vertex_type e;
      if (!reset && rsp_valid) begin
         if (pending_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word x=%h", rsp_new_x);
         end else begin
            e = pending_vertices.pop_front();
            if (rsp_new_x !== e.x || rsp_new_y !== e.y || rsp_new_z !== e.z ||
                rsp_fatigue_out !== e.fatigue || rsp_inside_res !== e.hit ||
                rsp_last_out !== e.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected x=%h y=%h z=%h f=%h in=%b last=%b",
                           e.x, e.y, e.z, e.fatigue, e.hit, e.last);
                  $display("          actual   x=%h y=%h z=%h f=%h in=%b last=%b",
                           rsp_new_x, rsp_new_y, rsp_new_z, rsp_fatigue_out,
                           rsp_inside_res, rsp_last_out);
               end
            end
         end
      end
   end

   // Sends one word. Start stays high across a burst; between bursts the
   // sender drops start for a random number of cycles.
   task automatic send_vertex(vertex_word_type w);
      @(negedge clock);
      start <= 1'b1;
      req_vertex_x <= w.x;
      req_vertex_y <= w.y;
      req_vertex_z <= w.z;
      req_fatigue_in <= w.fatigue;
      req_pressure_in <= w.pressure;
      req_last_vertex <= w.last;
      do @(posedge clock); while (busy);
      pending_vertices.insert(pending_vertices.size(), poke_vertex(w));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Registers change only once the pipeline has fully drained.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (spvi_pkg::RSP_LAT + 10) @(posedge clock);
   endtask

   task automatic write_reg(spvi_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         spvi_pkg::CSR_ORIGIN_X:    poke_origin[0] = value;
         spvi_pkg::CSR_ORIGIN_Y:    poke_origin[1] = value;
         spvi_pkg::CSR_ORIGIN_Z:    poke_origin[2] = value;
         spvi_pkg::CSR_DIR_X:       poke_dir[0] = value;
         spvi_pkg::CSR_DIR_Y:       poke_dir[1] = value;
         spvi_pkg::CSR_DIR_Z:       poke_dir[2] = value;
         spvi_pkg::CSR_RADIUS:      poke_radius = value[62:0];
         spvi_pkg::CSR_INDENT_GAIN: poke_gain = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(logic [63:0] ox, logic [63:0] oy, logic [63:0] oz,
                            logic [63:0] dx, logic [63:0] dy, logic [63:0] dz,
                            logic [63:0] rad, logic [63:0] gain);
      write_reg(spvi_pkg::CSR_ORIGIN_X, ox);
      write_reg(spvi_pkg::CSR_ORIGIN_Y, oy);
      write_reg(spvi_pkg::CSR_ORIGIN_Z, oz);
      write_reg(spvi_pkg::CSR_DIR_X, dx);
      write_reg(spvi_pkg::CSR_DIR_Y, dy);
      write_reg(spvi_pkg::CSR_DIR_Z, dz);
      write_reg(spvi_pkg::CSR_RADIUS, rad);
      write_reg(spvi_pkg::CSR_INDENT_GAIN, gain);
   endtask

   function automatic vertex_word_type make_word(logic [63:0] x, logic [63:0] y,
                                                 logic [63:0] z, logic [63:0] f,
                                                 logic [63:0] p, logic l);
      vertex_word_type w;
      w.x = x; w.y = y; w.z = z; w.fatigue = f; w.pressure = p; w.last = l;
      return w;
   endfunction

   // A coordinate somewhere inside (or just past) the radius around c.
   function automatic logic [63:0] near_coord(logic [63:0] c);
      logic [64:0] span, off;
      span = {2'b0, poke_radius} + {2'b0, poke_radius} + 65'd1;
      off = {1'b0, rand64()} % span;
      return c + off[63:0] - {1'b0, poke_radius};
   endfunction

   // Reset values: radius 1.0 around the origin, no movement, so only the
   // fatigue changes. Covers the rim, the fatigue saturation, and vertices
   // far enough away that the squared distance saturates.
   task automatic test_reset_values();
      poke_origin = '{default: '0};
      poke_dir = '{default: '0};
      poke_radius = ONE_Q[62:0];
      poke_gain = '0;
      send_vertex(make_word('0, '0, '0, '0, ONE_Q, 1'b0));
      send_vertex(make_word('0, '0, '0, SMAX, SMAX, 1'b1));
      send_vertex(make_word('0, '0, '0, SMIN, SMIN, 1'b0));
      send_vertex(make_word(ONE_Q, '0, '0, '0, ONE_Q, 1'b1));
      send_vertex(make_word(ONE_Q - 1, '0, '0, SMAX, '1, 1'b0));
      send_vertex(make_word(SMAX, SMAX, SMAX, 64'h1234, SMAX, 1'b1));
      send_vertex(make_word(SMIN, SMIN, SMIN, SMIN, SMIN, 1'b0));
      send_vertex(make_word('1, '1, '1, '1, '1, 1'b1));
      wait_drained();
   endtask

   // Largest radius and extreme directions and gains drive the position
   // updates into saturation at both ends.
   task automatic test_extreme_registers();
      write_all('0, '0, '0, SMAX, SMIN, ONE_Q, {1'b0, SMAX[62:0]}, SMAX);
      send_vertex(make_word('0, '0, '0, '0, SMAX, 1'b0));
      send_vertex(make_word(ONE_Q, SMIN, '0, '0, ONE_Q, 1'b1));
      send_vertex(make_word(SMAX, '0, '0, SMIN, SMIN, 1'b0));
      wait_drained();
      write_all(SMAX, SMIN, '1, SMIN, SMAX, '1, {1'b0, SMAX[62:0]}, SMIN);
      send_vertex(make_word(SMAX, SMIN, '1, '0, ONE_Q, 1'b1));
      send_vertex(make_word(SMIN, SMAX, '0, SMAX, SMAX, 1'b0));
      send_vertex(make_word(SMAX - ONE_Q, SMIN + ONE_Q, '0, '0, '1, 1'b1));
      wait_drained();
   endtask

   // A radius of one raw step squares to zero, so nothing is inside.
   task automatic test_tiny_radius();
      write_all('0, '0, '0, ONE_Q, ONE_Q, ONE_Q, 64'd1, ONE_Q);
      send_vertex(make_word('0, '0, '0, '0, ONE_Q, 1'b0));
      send_vertex(make_word(64'd1, '0, '0, SMAX, SMAX, 1'b1));
      send_vertex(make_word(SMIN, SMAX, '0, SMIN, SMIN, 1'b0));
      wait_drained();
   endtask

   task automatic test_random_phases();
      logic [63:0] rad;
      vertex_word_type w;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0: rad = {32'($urandom_range(1, 16)), $urandom} & SMAX;
            1: rad = {28'd0, 4'($urandom_range(0, 15)), $urandom} & SMAX;
            2: rad = rand64();
            default: rad = {16'd0, 16'($urandom_range(0, 65535)), $urandom};
         endcase
         if (rad[62:0] == 0) rad = 64'd1;
         if ($urandom_range(0, 1))
            write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rad,
                      rand64());
         else
            write_all({{16{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 16'($urandom), $urandom},
                      64'($signed($urandom)) <<< 8, 64'($signed($urandom)),
                      64'($signed($urandom_range(0, 16'hFFFF) - 32768)) <<< 19,
                      64'($signed($urandom)) <<< 2, 64'($signed($urandom)) <<< 3,
                      rad, 64'($signed($urandom)) <<< 4);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if ($urandom_range(0, 4) != 0)
               w = make_word(near_coord(poke_origin[0]), near_coord(poke_origin[1]),
                             near_coord(poke_origin[2]), rand64(), rand64(),
                             1'($urandom));
            else
               w = make_word(rand64(), rand64(), rand64(), rand64(), rand64(),
                             1'($urandom));
            if ($urandom_range(0, 15) == 0) w.fatigue = $urandom_range(0, 1) ? SMAX : SMIN;
            if ($urandom_range(0, 15) == 0) w.pressure = $urandom_range(0, 1) ? SMAX : SMIN;
            send_vertex(w);
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_extreme_registers();
      test_tiny_radius();
      test_random_phases();
      if (mismatches == 0 && pending_vertices.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
